@@ rtl/core/bpmd_pkg.sv @@
// Package for the balance PID motor drive.
// Holds widths, filter and reset constants, FSM and register-index enums, control structs
// and the radix-4 Booth digit helper. No dependencies.
package bpmd_pkg;

	localparam int ANGLE_FRAC_BITS = 8;
	localparam int GAIN_FRAC_BITS  = 16;
	localparam int FRAC_BITS       = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;

	localparam int GAIN_W    = 24;
	localparam int DIGITS    = GAIN_W / 2;
	localparam int X_W       = 32;
	localparam int PP_W      = X_W + 2;
	localparam int ACC_S_W   = 36;
	localparam int ACC_T_W   = 24;
	localparam int DRV_W     = 57;
	localparam int CNT_W     = 4;

	localparam int FILT_STEPS = 8;
	localparam logic [FILT_STEPS-1:0] FILT_NEW = 8'd77;
	localparam logic [FILT_STEPS-1:0] FILT_OLD = 8'd179;

	localparam logic signed [23:0] GAIN_P_RST    = -24'sd6553600;
	localparam logic signed [23:0] GAIN_I_RST    = -24'sd32768;
	localparam logic signed [23:0] GAIN_D_RST    = -24'sd163840;
	localparam logic signed [23:0] GAIN_TURN_RST = 24'sd1966;
	localparam logic signed [13:0] LEVEL_OFFSET_RST  = 14'sd51;
	localparam logic [12:0]        INTEGRAL_BAND_RST = 13'd256;
	localparam logic [15:0]        TILT_CUTOFF_RST   = 16'd7680;
	localparam logic [9:0]         DRIVE_LIMIT_RST   = 10'd1000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILT,
		ST_INTEG,
		ST_MAC,
		ST_SUM,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_GAIN_TURN,
		REG_LEVEL_OFFSET,
		REG_INTEGRAL_BAND,
		REG_TILT_CUTOFF,
		REG_DRIVE_LIMIT
	} cfg_idx_t;

	typedef struct packed {
		logic load;
		logic step;
	} mac_ctrl_t;

	typedef struct packed {
		logic      take;
		logic      filt_step;
		logic      integ;
		mac_ctrl_t mac;
		logic      sum;
		logic      fin;
	} ctl_t;

	// digit = {b(2i+1), b(2i), b(2i-1)}
	function automatic logic signed [PP_W-1:0] booth_pp(input logic [2:0] dig,
			input logic signed [X_W-1:0] x);
		logic signed [PP_W-1:0] xe;
		xe = PP_W'(x);
		case (dig)
			3'b001, 3'b010: return xe;
			3'b011:         return xe <<< 1;
			3'b100:         return -(xe <<< 1);
			3'b101, 3'b110: return -xe;
			default:        return '0;
		endcase
	endfunction

endpackage

@@ rtl/core/balance_pid_motor_drive.sv @@
// Top level of the balance PID motor drive: config registers, filter, integrator,
// sequencer, drive truncation, clamp and duty split. Depends on bpmd_pkg, bpmd_mac.
//
// channel  direction  handshake            payload
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
// in       in         in_valid/in_stall    tilt_angle, tilt_rate, yaw_rate, steer_cmd, lean_cmd
// out      out        out_valid/out_stall  left_/right_ forward/reverse, stopped
//
// A request is taken only in the idle state, so the next one waits until this one is finished.
// Each passes the 8-step bit-serial error filter, the integrator and the 12 radix-4 Booth steps of the MAC.
// The finished result waits in the output register, so a new request is taken while it stalls;
// the next result waits at the last step until the output register is free.
// arst_n clears the sequencer, filter/integrator state, held duties and loads register defaults.
module balance_pid_motor_drive (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [16:0] tilt_angle,
	input  logic signed [19:0] tilt_rate,
	input  logic signed [19:0] yaw_rate,
	input  logic signed [10:0] steer_cmd,
	input  logic signed [13:0] lean_cmd,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [9:0]         left_forward,
	output logic [9:0]         left_reverse,
	output logic [9:0]         right_forward,
	output logic [9:0]         right_reverse,
	output logic               stopped
);

	logic signed [23:0] gain_p_q, gain_i_q, gain_d_q, gain_turn_q;
	logic signed [13:0] level_offset_q;
	logic [12:0]        integral_band_q;
	logic [15:0]        tilt_cutoff_q;
	logic [9:0]         drive_limit_q;

	bpmd_pkg::state_t st_q, st_nxt;
	bpmd_pkg::ctl_t   ctl;
	logic [bpmd_pkg::CNT_W-1:0] cnt_q;
	logic out_free;

	logic signed [18:0] err_q;
	logic [17:0]        level_abs_q;
	logic signed [19:0] rate_q, yaw_q;
	logic signed [10:0] steer_q;

	logic signed [17:0] level;
	logic signed [18:0] err;
	logic [17:0]        level_abs;

	logic signed [21:0] fa_q, fa_add;
	logic signed [19:0] fe_q, fe_new;
	logic signed [31:0] int_q, int_sat;
	logic signed [32:0] int_sum;
	logic               in_band;

	logic signed [bpmd_pkg::ACC_S_W-1:0] s_hi;
	logic [bpmd_pkg::GAIN_W-1:0]         s_lo, t_lo;
	logic signed [bpmd_pkg::ACC_T_W-1:0] t_hi;
	logic signed [11:0]                  steer_neg;
	logic signed [bpmd_pkg::DRV_W-1:0]   s_full, t_full, l_q, r_q;

	logic signed [10:0] drv_l, drv_r;
	logic               stop;
	logic [19:0]        lduty_q, rduty_q, lduty_nxt, rduty_nxt;
	logic [9:0]         lf_q, lr_q, rf_q, rr_q;
	logic               stopped_q, out_valid_q;

	// truncate toward zero to whole duty units, clamp to +-lim
	function automatic logic signed [10:0] drive_of(input logic signed [bpmd_pkg::DRV_W-1:0] v,
			input logic [9:0] lim);
		logic signed [32:0] hi;
		logic signed [32:0] tr;
		logic signed [32:0] lim_s;
		hi    = $signed(v[bpmd_pkg::DRV_W-1:bpmd_pkg::FRAC_BITS]);
		tr    = hi + $signed({32'd0, v[bpmd_pkg::DRV_W-1] & (|v[bpmd_pkg::FRAC_BITS-1:0])});
		lim_s = $signed({23'd0, lim});
		if (tr > lim_s)
			return 11'(lim_s);
		else if (tr < -lim_s)
			return 11'(-lim_s);
		else
			return 11'(tr);
	endfunction

	// forward in low half, reverse in high half; zero drive holds
	function automatic logic [19:0] side_duty(input logic signed [10:0] d,
			input logic [19:0] held);
		logic signed [10:0] mag;
		mag = -d;
		if (d > 11'sd0)
			return {10'd0, d[9:0]};
		else if (d < 11'sd0)
			return {mag[9:0], 10'd0};
		else
			return held;
	endfunction

	// config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q        <= bpmd_pkg::GAIN_P_RST;
			gain_i_q        <= bpmd_pkg::GAIN_I_RST;
			gain_d_q        <= bpmd_pkg::GAIN_D_RST;
			gain_turn_q     <= bpmd_pkg::GAIN_TURN_RST;
			level_offset_q  <= bpmd_pkg::LEVEL_OFFSET_RST;
			integral_band_q <= bpmd_pkg::INTEGRAL_BAND_RST;
			tilt_cutoff_q   <= bpmd_pkg::TILT_CUTOFF_RST;
			drive_limit_q   <= bpmd_pkg::DRIVE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (bpmd_pkg::cfg_idx_t'(cfg_index))
				bpmd_pkg::REG_GAIN_P:        gain_p_q        <= cfg_data;
				bpmd_pkg::REG_GAIN_I:        gain_i_q        <= cfg_data;
				bpmd_pkg::REG_GAIN_D:        gain_d_q        <= cfg_data;
				bpmd_pkg::REG_GAIN_TURN:     gain_turn_q     <= cfg_data;
				bpmd_pkg::REG_LEVEL_OFFSET:  level_offset_q  <= cfg_data[13:0];
				bpmd_pkg::REG_INTEGRAL_BAND: integral_band_q <= cfg_data[12:0];
				bpmd_pkg::REG_TILT_CUTOFF:   tilt_cutoff_q   <= cfg_data[15:0];
				bpmd_pkg::REG_DRIVE_LIMIT:   drive_limit_q   <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// sequencer
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			bpmd_pkg::ST_IDLE:  if (in_valid) st_nxt = bpmd_pkg::ST_FILT;
			bpmd_pkg::ST_FILT:
				if (cnt_q == bpmd_pkg::CNT_W'(bpmd_pkg::FILT_STEPS - 1))
					st_nxt = bpmd_pkg::ST_INTEG;
			bpmd_pkg::ST_INTEG: st_nxt = bpmd_pkg::ST_MAC;
			bpmd_pkg::ST_MAC:
				if (cnt_q == bpmd_pkg::CNT_W'(bpmd_pkg::DIGITS - 1))
					st_nxt = bpmd_pkg::ST_SUM;
			bpmd_pkg::ST_SUM:   st_nxt = bpmd_pkg::ST_FIN;
			bpmd_pkg::ST_FIN:   if (out_free) st_nxt = bpmd_pkg::ST_IDLE;
			default:            st_nxt = bpmd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_stall = 1'b1;
		case (st_q)
			bpmd_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				ctl.take = in_valid;
			end
			bpmd_pkg::ST_FILT:  ctl.filt_step = 1'b1;
			bpmd_pkg::ST_INTEG: begin
				ctl.integ    = 1'b1;
				ctl.mac.load = 1'b1;
			end
			bpmd_pkg::ST_MAC:   ctl.mac.step = 1'b1;
			bpmd_pkg::ST_SUM:   ctl.sum = 1'b1;
			bpmd_pkg::ST_FIN:   ctl.fin = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= bpmd_pkg::ST_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_nxt;
			if (ctl.take || ctl.integ)
				cnt_q <= '0;
			else if (ctl.filt_step || ctl.mac.step)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	// request capture
	always_comb begin
		level     = 18'(tilt_angle) + 18'(level_offset_q);
		err       = 19'(level) - 19'(lean_cmd);
		level_abs = level[17] ? 18'(-level) : 18'(level);
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			err_q       <= err;
			level_abs_q <= level_abs;
			rate_q      <= tilt_rate;
			yaw_q       <= yaw_rate;
			steer_q     <= steer_cmd;
		end
	end

	// error filter, one constant bit per cycle, floor by right shift
	always_comb begin
		fa_add = fa_q
			+ (bpmd_pkg::FILT_NEW[cnt_q[2:0]] ? 22'(err_q) : 22'sd0)
			+ (bpmd_pkg::FILT_OLD[cnt_q[2:0]] ? 22'(fe_q) : 22'sd0);
		fe_new  = fa_q[19:0];
		int_sum = 33'(int_q) + 33'(fe_new);
		if (int_sum[32] != int_sum[31])
			int_sat = int_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			int_sat = int_sum[31:0];
		in_band = level_abs_q < 18'(integral_band_q);
	end

	always_ff @(posedge clk) begin
		if (ctl.take)
			fa_q <= '0;
		else if (ctl.filt_step)
			fa_q <= fa_add >>> 1;
	end

	// MAC
	bpmd_mac u_mac (
		.clk       (clk),
		.ctrl      (ctl.mac),
		.gain_p    (gain_p_q),
		.gain_i    (gain_i_q),
		.gain_d    (gain_d_q),
		.gain_turn (gain_turn_q),
		.err       (err_q),
		.integ     (int_q),
		.rate      (rate_q),
		.yaw       (yaw_q),
		.s_hi      (s_hi),
		.s_lo      (s_lo),
		.t_hi      (t_hi),
		.t_lo      (t_lo)
	);

	// left = pid + yaw term, right = pid - yaw term; steer replaces the yaw term
	always_comb begin
		steer_neg = -12'(steer_q);
		s_full    = $signed({s_hi[32:0], s_lo});
		if (steer_q != 11'sd0)
			t_full = $signed({{21{steer_neg[11]}}, steer_neg, 24'd0});
		else
			t_full = $signed({{9{t_hi[23]}}, t_hi, t_lo});
	end

	always_ff @(posedge clk) begin
		if (ctl.sum) begin
			l_q <= s_full + t_full;
			r_q <= s_full - t_full;
		end
	end

	always_comb begin
		drv_l     = drive_of(l_q, drive_limit_q);
		drv_r     = drive_of(r_q, drive_limit_q);
		stop      = (level_abs_q > 18'(tilt_cutoff_q)) || (drv_l == 11'sd0 && drv_r == 11'sd0);
		lduty_nxt = stop ? 20'd0 : side_duty(drv_l, lduty_q);
		rduty_nxt = stop ? 20'd0 : side_duty(drv_r, rduty_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_q        <= '0;
			int_q       <= '0;
			lduty_q     <= '0;
			rduty_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.integ) begin
				fe_q  <= in_band ? 20'sd0 : fe_new;
				int_q <= in_band ? 32'sd0 : int_sat;
			end else if (ctl.fin && stop) begin
				fe_q  <= '0;
				int_q <= '0;
			end
			if (ctl.fin) begin
				lduty_q     <= lduty_nxt;
				rduty_q     <= rduty_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			lf_q      <= lduty_nxt[9:0];
			lr_q      <= lduty_nxt[19:10];
			rf_q      <= rduty_nxt[9:0];
			rr_q      <= rduty_nxt[19:10];
			stopped_q <= stop;
		end
	end

	assign out_valid     = out_valid_q;
	assign left_forward  = lf_q;
	assign left_reverse  = lr_q;
	assign right_forward = rf_q;
	assign right_reverse = rr_q;
	assign stopped       = stopped_q;

endmodule

@@ rtl/core/bpmd_mac.sv @@
// Digit-serial multiply-accumulate for the balance PID motor drive.
// Radix-4 Booth over the gains, two gain bits per cycle; PID and turn accumulators.
// Depends on bpmd_pkg.
module bpmd_mac (
	input  logic                                   clk,
	input  bpmd_pkg::mac_ctrl_t                    ctrl,
	input  logic signed [bpmd_pkg::GAIN_W-1:0]     gain_p,
	input  logic signed [bpmd_pkg::GAIN_W-1:0]     gain_i,
	input  logic signed [bpmd_pkg::GAIN_W-1:0]     gain_d,
	input  logic signed [bpmd_pkg::GAIN_W-1:0]     gain_turn,
	input  logic signed [18:0]                     err,
	input  logic signed [31:0]                     integ,
	input  logic signed [19:0]                     rate,
	input  logic signed [19:0]                     yaw,
	output logic signed [bpmd_pkg::ACC_S_W-1:0]    s_hi,
	output logic        [bpmd_pkg::GAIN_W-1:0]     s_lo,
	output logic signed [bpmd_pkg::ACC_T_W-1:0]    t_hi,
	output logic        [bpmd_pkg::GAIN_W-1:0]     t_lo
);

	logic signed [bpmd_pkg::GAIN_W-1:0]  gp_q, gi_q, gd_q, gt_q;
	logic [3:0]                          prev_q;
	logic signed [bpmd_pkg::ACC_S_W-1:0] acc_s_q;
	logic [bpmd_pkg::GAIN_W-1:0]         lo_s_q;
	logic signed [bpmd_pkg::ACC_T_W-1:0] acc_t_q;
	logic [bpmd_pkg::GAIN_W-1:0]         lo_t_q;

	logic signed [bpmd_pkg::PP_W-1:0]    pp_p, pp_i, pp_d, pp_t;
	logic signed [bpmd_pkg::ACC_S_W-1:0] sum_s;
	logic signed [bpmd_pkg::ACC_T_W-1:0] sum_t;

	always_comb begin
		pp_p  = bpmd_pkg::booth_pp({gp_q[1:0], prev_q[0]}, bpmd_pkg::X_W'(err));
		pp_i  = bpmd_pkg::booth_pp({gi_q[1:0], prev_q[1]}, bpmd_pkg::X_W'(integ));
		pp_d  = bpmd_pkg::booth_pp({gd_q[1:0], prev_q[2]}, bpmd_pkg::X_W'(rate));
		pp_t  = bpmd_pkg::booth_pp({gt_q[1:0], prev_q[3]}, bpmd_pkg::X_W'(yaw));
		sum_s = acc_s_q + bpmd_pkg::ACC_S_W'(pp_p) + bpmd_pkg::ACC_S_W'(pp_i)
			+ bpmd_pkg::ACC_S_W'(pp_d);
		sum_t = acc_t_q + $signed(pp_t[bpmd_pkg::ACC_T_W-1:0]);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			gp_q    <= gain_p;
			gi_q    <= gain_i;
			gd_q    <= gain_d;
			gt_q    <= gain_turn;
			prev_q  <= '0;
			acc_s_q <= '0;
			lo_s_q  <= '0;
			acc_t_q <= '0;
			lo_t_q  <= '0;
		end else if (ctrl.step) begin
			gp_q    <= gp_q >>> 2;
			gi_q    <= gi_q >>> 2;
			gd_q    <= gd_q >>> 2;
			gt_q    <= gt_q >>> 2;
			prev_q  <= {gt_q[1], gd_q[1], gi_q[1], gp_q[1]};
			acc_s_q <= sum_s >>> 2;
			lo_s_q  <= {sum_s[1:0], lo_s_q[bpmd_pkg::GAIN_W-1:2]};
			acc_t_q <= sum_t >>> 2;
			lo_t_q  <= {sum_t[1:0], lo_t_q[bpmd_pkg::GAIN_W-1:2]};
		end
	end

	assign s_hi = acc_s_q;
	assign s_lo = lo_s_q;
	assign t_hi = acc_t_q;
	assign t_lo = lo_t_q;

endmodule
